/* hw/rtl/wmmem_pkg.sv */
// ---------------------------------------------------------------------------
// Windowed min/max edge monitor package
// Shared constants, channel codes, the pulse-side report snapshot type and the serializer status type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wmmem_pkg;

    // Default sample width and register reset value
    localparam int          SAMPLE_BITS_DEF = 12;
    localparam logic [15:0] WINDOW_RESET    = 16'd2400;

    localparam int NUM_ANALOG = 4;
    localparam int NUM_PULSE  = 2;
    localparam int NUM_CHAN   = NUM_ANALOG + NUM_PULSE;
    localparam int EDGE_BITS  = 16;
    localparam int SEQ_BITS   = 32;
    localparam int CHAN_BITS  = 3;

    // Channel codes, in report order
    localparam logic [CHAN_BITS-1:0] CH_AUDIO1 = 3'd0;
    localparam logic [CHAN_BITS-1:0] CH_AUDIO2 = 3'd1;
    localparam logic [CHAN_BITS-1:0] CH_CV1    = 3'd2;
    localparam logic [CHAN_BITS-1:0] CH_CV2    = 3'd3;
    localparam logic [CHAN_BITS-1:0] CH_PULSE1 = 3'd4;
    localparam logic [CHAN_BITS-1:0] CH_PULSE2 = 3'd5;

    // Pulse channels, connect flags and report number of one report
    typedef struct packed {
        logic [NUM_PULSE-1:0]                level;
        logic [NUM_PULSE-1:0][EDGE_BITS-1:0] edges;
        logic [NUM_CHAN-1:0]                 conn;
        logic [SEQ_BITS-1:0]                 seq;
    } pulse_snap_t;

    // Serializer status seen by the input side
    typedef struct packed {
        logic busy;
        logic done;
    } ser_status_t;

endpackage

/* hw/rtl/wmmem_stats.sv */
// ---------------------------------------------------------------------------
// Windowed min/max edge monitor - window statistics
// Running min/max per analog channel, rising edge counts per pulse input,
// frame counter and report number. Flags the frame that closes a window.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmmem_stats
    import wmmem_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [15:0]                   window_length_i,
    input  logic                          accept_i,
    input  logic signed [SAMPLE_BITS-1:0] sample_i [NUM_ANALOG],
    input  logic [NUM_PULSE-1:0]          level_i,
    input  logic [NUM_CHAN-1:0]           conn_i,
    output logic                          will_report_o,
    output logic signed [SAMPLE_BITS-1:0] min_o [NUM_ANALOG],
    output logic signed [SAMPLE_BITS-1:0] max_o [NUM_ANALOG],
    output pulse_snap_t                   pulse_o
);

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] min_reg [NUM_ANALOG];
    logic signed [SAMPLE_BITS-1:0] max_reg [NUM_ANALOG];
    logic signed [SAMPLE_BITS-1:0] min_next [NUM_ANALOG];
    logic signed [SAMPLE_BITS-1:0] max_next [NUM_ANALOG];
    logic [EDGE_BITS-1:0]          edges_reg [NUM_PULSE];
    logic [EDGE_BITS-1:0]          edges_next [NUM_PULSE];
    logic [NUM_PULSE-1:0]          prev_reg;
    logic [15:0]                   frames_reg;
    logic [15:0]                   frames_next;
    logic [15:0]                   limit;
    logic [SEQ_BITS-1:0]           report_num_reg;
    logic [SEQ_BITS-1:0]           report_num_next;
    logic                          report;

    // Window close check: zero length acts as one
    assign frames_next     = frames_reg + 16'd1;
    assign limit           = (window_length_i == 16'd0) ? 16'd1 : window_length_i;
    assign will_report_o   = (frames_next >= limit);
    assign report          = accept_i && will_report_o;
    assign report_num_next = report_num_reg + 32'd1;

    // Range update including this frame
    always_comb begin
        for (int i = 0; i < NUM_ANALOG; i++) begin
            min_next[i] = (sample_i[i] < min_reg[i]) ? sample_i[i] : min_reg[i];
            max_next[i] = (sample_i[i] > max_reg[i]) ? sample_i[i] : max_reg[i];
        end
    end

    // Rising edge counts, wrap at 16 bits
    always_comb begin
        for (int i = 0; i < NUM_PULSE; i++) begin
            edges_next[i] = edges_reg[i] + EDGE_BITS'(level_i[i] & ~prev_reg[i]);
        end
    end

    // Snapshot values for the serializer
    always_comb begin
        min_o = min_next;
        max_o = max_next;
        pulse_o.level = level_i;
        pulse_o.conn  = conn_i;
        pulse_o.seq   = report_num_next;
        for (int i = 0; i < NUM_PULSE; i++) begin
            pulse_o.edges[i] = edges_next[i];
        end
    end

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ANALOG; i++) begin
                min_reg[i] <= SMAX;
                max_reg[i] <= SMIN;
            end
            for (int i = 0; i < NUM_PULSE; i++) begin
                edges_reg[i] <= '0;
            end
            prev_reg       <= '0;
            frames_reg     <= '0;
            report_num_reg <= '0;
        end else if (accept_i) begin
            prev_reg <= level_i;
            if (report) begin
                for (int i = 0; i < NUM_ANALOG; i++) begin
                    min_reg[i] <= SMAX;
                    max_reg[i] <= SMIN;
                end
                for (int i = 0; i < NUM_PULSE; i++) begin
                    edges_reg[i] <= '0;
                end
                frames_reg     <= '0;
                report_num_reg <= report_num_next;
            end else begin
                min_reg    <= min_next;
                max_reg    <= max_next;
                edges_reg  <= edges_next;
                frames_reg <= frames_next;
            end
        end
    end

    // Checks
    a_clear_after_report: assert property (@(posedge aclk) disable iff (!aresetn)
        report |=> (frames_reg == 16'd0) && (edges_reg[0] == '0) && (edges_reg[1] == '0))
        else $error("window state not cleared after report");

    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        report |=> report_num_reg == $past(report_num_reg) + 32'd1)
        else $error("report number did not advance by one");

    a_seq_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !report |=> $stable(report_num_reg))
        else $error("report number moved without a report");

endmodule

/* hw/rtl/wmmem_serializer.sv */
// ---------------------------------------------------------------------------
// Windowed min/max edge monitor - report serializer
// Holds one report snapshot and sends its six channel results in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmmem_serializer
    import wmmem_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int OUT_W       = ((3 * SAMPLE_BITS + EDGE_BITS + 1 + SEQ_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load_i,
    input  logic signed [SAMPLE_BITS-1:0] cur_i [NUM_ANALOG],
    input  logic signed [SAMPLE_BITS-1:0] min_i [NUM_ANALOG],
    input  logic signed [SAMPLE_BITS-1:0] max_i [NUM_ANALOG],
    input  pulse_snap_t                   pulse_i,
    output ser_status_t                   status_o,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_W-1:0]              m_tdata,
    output logic [CHAN_BITS-1:0]          m_tuser,
    output logic                          m_tlast
);

    localparam int USED_W = 3 * SAMPLE_BITS + EDGE_BITS + 1 + SEQ_BITS;

    logic signed [SAMPLE_BITS-1:0] cur_reg [NUM_ANALOG];
    logic signed [SAMPLE_BITS-1:0] min_reg [NUM_ANALOG];
    logic signed [SAMPLE_BITS-1:0] max_reg [NUM_ANALOG];
    pulse_snap_t                   pulse_reg;
    logic [CHAN_BITS-1:0]          idx_reg;
    logic                          busy_reg;
    logic                          last_take;

    logic signed [SAMPLE_BITS-1:0] cur_val;
    logic signed [SAMPLE_BITS-1:0] min_val;
    logic signed [SAMPLE_BITS-1:0] max_val;
    logic [EDGE_BITS-1:0]          edge_val;
    logic                          pidx;

    assign last_take       = busy_reg && m_tready && (idx_reg == CH_PULSE2);
    assign status_o.busy   = busy_reg;
    assign status_o.done   = last_take;

    // Snapshot and result counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= CH_AUDIO1;
        end else if (load_i) begin
            busy_reg <= 1'b1;
            idx_reg  <= CH_AUDIO1;
        end else if (busy_reg && m_tready) begin
            if (idx_reg == CH_PULSE2) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
        if (load_i) begin
            cur_reg   <= cur_i;
            min_reg   <= min_i;
            max_reg   <= max_i;
            pulse_reg <= pulse_i;
        end
    end

    // Field select for the current channel
    assign pidx = 1'(idx_reg - CH_PULSE1);

    always_comb begin
        if (idx_reg >= CH_PULSE1) begin
            cur_val  = SAMPLE_BITS'(pulse_reg.level[pidx]);
            min_val  = '0;
            max_val  = '0;
            edge_val = pulse_reg.edges[pidx];
        end else begin
            cur_val  = cur_reg[idx_reg[1:0]];
            min_val  = min_reg[idx_reg[1:0]];
            max_val  = max_reg[idx_reg[1:0]];
            edge_val = '0;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tuser  = idx_reg;
    assign m_tlast  = (idx_reg == CH_PULSE2);
    assign m_tdata  = {{(OUT_W - USED_W){1'b0}}, pulse_reg.seq, pulse_reg.conn[idx_reg],
                       edge_val, max_val, min_val, cur_val};

    // Checks
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_i |-> (!busy_reg || last_take))
        else $error("report loaded over one still being sent");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg <= CH_PULSE2))
        else $error("channel index out of range");

    a_start_first: assert property (@(posedge aclk) disable iff (!aresetn)
        load_i |=> busy_reg && (idx_reg == CH_AUDIO1))
        else $error("report did not start at first channel");

endmodule

/* hw/rtl/windowed_min_max_edge_monitor_top.sv */
// ---------------------------------------------------------------------------
// Windowed min/max edge monitor - top level
// One sample frame per cycle unless stalled, and per-channel window reports.
// ---------------------------------------------------------------------------
// One sample frame is taken per clock unless a closing frame stalls. Each
// frame updates the running min/max of the four analog channels and the rising
// edge counts of the two pulse inputs. The frame that closes a window
// (window_length frames, zero counts as one) copies the results into a report
// register, and six results leave on the m_ side, channel 0 to 5, tlast on
// channel 5. Frames that do not close a window keep flowing meanwhile; a
// closing frame waits only while an earlier report is still being sent, so
// with m_tready held high, windows of six frames or more run at one frame per
// clock. Write window_length only while no report is pending.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module windowed_min_max_edge_monitor_top
    import wmmem_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int IN_W  = ((4 * SAMPLE_BITS + NUM_PULSE + NUM_CHAN + 7) / 8) * 8,
    parameter int OUT_W = ((3 * SAMPLE_BITS + EDGE_BITS + 1 + SEQ_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // window_length register
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata,
    // tdata, low bit up: audio1_sample, audio2_sample, cv1_sample, cv2_sample,
    // pulse1_level, pulse2_level, connected_mask
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,
    // tdata, low bit up: current_value, window_min, window_max, edge_count,
    // is_connected, sequence_res
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,
    // tuser: channel
    output logic [CHAN_BITS-1:0] m_tuser,
    output logic                 m_tlast
);

    localparam int PULSE_LSB = 4 * SAMPLE_BITS;
    localparam int CONN_LSB  = PULSE_LSB + NUM_PULSE;

    logic [15:0]                   window_length_reg;
    logic signed [SAMPLE_BITS-1:0] sample [NUM_ANALOG];
    logic signed [SAMPLE_BITS-1:0] min_snap [NUM_ANALOG];
    logic signed [SAMPLE_BITS-1:0] max_snap [NUM_ANALOG];
    pulse_snap_t                   pulse_snap;
    ser_status_t                   ser_status;
    logic                          will_report;
    logic                          accept;
    logic                          load;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= WINDOW_RESET;
        end else if (cfg_we) begin
            window_length_reg <= cfg_wdata;
        end
    end

    // Unpack frame
    always_comb begin
        for (int i = 0; i < NUM_ANALOG; i++) begin
            sample[i] = s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
        end
    end

    // Closing frame waits for the report register to free up
    assign s_tready = !ser_status.busy || ser_status.done || !will_report;
    assign accept   = s_tvalid && s_tready;
    assign load     = accept && will_report;

    wmmem_stats #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_stats (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .window_length_i (window_length_reg),
        .accept_i        (accept),
        .sample_i        (sample),
        .level_i         (s_tdata[PULSE_LSB +: NUM_PULSE]),
        .conn_i          (s_tdata[CONN_LSB +: NUM_CHAN]),
        .will_report_o   (will_report),
        .min_o           (min_snap),
        .max_o           (max_snap),
        .pulse_o         (pulse_snap)
    );

    wmmem_serializer #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .OUT_W       (OUT_W)
    ) u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_i   (load),
        .cur_i    (sample),
        .min_i    (min_snap),
        .max_i    (max_snap),
        .pulse_i  (pulse_snap),
        .status_o (ser_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
